/* rtl/firfc_pkg.sv */
// ----------------------------------------------------------------------------
// FIR full convolution package
// Shared widths, word types, request codes and the control bundle that the
// sequencer hands to every tap cell.
// ----------------------------------------------------------------------------
package firfc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 36;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   // Request kinds carried in req_type.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_LOAD   = 1'b1;

   // Controls broadcast to the whole row of cells.
   typedef struct packed {
      logic       shift;      // move the delay line one place along
      logic       clear;      // zero the delay line at the end of a block
      sample_type coef_value; // coefficient for the cell whose write enable is set
   } cell_ctrl_type;

endpackage

/* rtl/firfc_req_if.sv */
// ----------------------------------------------------------------------------
// FIR request channel
// Valid/ready channel carrying sample words and coefficient load words.
// ----------------------------------------------------------------------------
interface firfc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic [firfc_pkg::INDEX_W-1:0]         tap_index;
   firfc_pkg::sample_type                 tap_value;
   firfc_pkg::sample_type                 sample_value;
   logic                                  last_sample;

   modport source (output valid, req_type, tap_index, tap_value, sample_value,
                   last_sample, input ready);
   modport sink   (input valid, req_type, tap_index, tap_value, sample_value,
                   last_sample, output ready);
endinterface

/* rtl/firfc_rsp_if.sv */
// ----------------------------------------------------------------------------
// FIR response channel
// Valid/ready channel carrying the convolution output words.
// ----------------------------------------------------------------------------
interface firfc_rsp_if;
   logic                  valid;
   logic                  ready;
   firfc_pkg::acc_type    filtered_value;
   logic                  last_output;

   modport source (output valid, filtered_value, last_output, input ready);
   modport sink   (input valid, filtered_value, last_output, output ready);
endinterface

/* rtl/firfc_cell.sv */
// ----------------------------------------------------------------------------
// FIR tap cell
// Holds one delay-line sample and one coefficient, forms their product and
// adds it to the partial sum handed on from the previous cell.
// ----------------------------------------------------------------------------
module firfc_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  firfc_pkg::cell_ctrl_type ctrl,
   input  logic                     coef_we,
   input  logic                     tap_enable,
   input  firfc_pkg::sample_type    sample_in,
   output firfc_pkg::sample_type    sample_out,
   input  firfc_pkg::acc_type       sum_in,
   output firfc_pkg::acc_type       sum_out
);

   firfc_pkg::sample_type delay_ff;
   firfc_pkg::sample_type coef_ff;
   firfc_pkg::prod_type   prod_ff;
   firfc_pkg::acc_type    sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         coef_ff  <= '0;
      end else begin
         if (ctrl.clear) begin
            delay_ff <= '0;
         end else if (ctrl.shift) begin
            delay_ff <= sample_in;
         end
         if (coef_we) begin
            coef_ff <= ctrl.coef_value;
         end
      end
   end

   // Product and partial sum: taps beyond the active count contribute zero.
   always_ff @(posedge clock) begin
      prod_ff <= tap_enable ? firfc_pkg::prod_type'(coef_ff * delay_ff) : '0;
      sum_ff  <= sum_in + firfc_pkg::acc_type'(prod_ff);
   end

   assign sample_out = delay_ff;
   assign sum_out    = sum_ff;

endmodule

/* rtl/fir_full_convolution.sv */
// ----------------------------------------------------------------------------
// FIR full convolution
// Block-wise full linear convolution of Q1.15 samples with a Q1.15 kernel,
// built as a row of multiply-accumulate tap cells with an exact Q6.30 sum.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Carries
//   req_port  in          valid / ready        sample or coefficient load word
//   rsp_port  out         valid / ready        36-bit sum and end-of-block flag
//   csr_*     in          csr_we, no stall     tap_count (5 bits)
//
// A coefficient load word gives no output. A sample word shifts the delay
// line at its accepting edge, and its output is written into the output
// register once the products have been formed, the partial sum has rippled
// down the row of cells and the settle counter is done. The request side is
// ready again in the following cycle, so a new sample word is not taken while
// one is still in the row. A sample marked last adds the active tap count less
// one tail outputs, each formed in the same way.
// Reset is synchronous and clears the delay line and coefficients and sets
// tap_count to 16. A stalled output word holds the sequencer only when a
// further output is ready to be written into the output register.
//
module fir_full_convolution #(
   parameter int TAPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   firfc_req_if.sink                     req_port,
   firfc_rsp_if.source                   rsp_port,
   input  logic                          csr_we,
   input  logic [firfc_pkg::COUNT_W-1:0] csr_wdata
);

   // Width of an active tap count (1 .. TAPS) and of the settle counter.
   localparam int CW     = $clog2(TAPS + 1);
   localparam int CNT_W  = $clog2(TAPS + 2);
   localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(TAPS + 1);

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   state_type                    state_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [CW-1:0]                tail_ff;
   logic [CW-1:0]                taps_ff;
   logic                         last_ff;
   logic [firfc_pkg::COUNT_W-1:0] tap_count_ff;
   logic                         rsp_valid_ff;
   firfc_pkg::acc_type           rsp_value_ff;
   logic                         rsp_last_ff;

   logic                         accept;
   logic                         accept_sample;
   logic                         capture;
   logic                         tail_left;
   logic [CW-1:0]                taps_eff;
   firfc_pkg::cell_ctrl_type     ctrl;

   firfc_pkg::sample_type        sample_chain [TAPS+1];
   firfc_pkg::acc_type           sum_chain    [TAPS+1];

   // The register value is clamped into the range 1 .. TAPS.
   always_comb begin
      if (tap_count_ff == '0) begin
         taps_eff = CW'(1);
      end else if (32'(tap_count_ff) > 32'(TAPS)) begin
         taps_eff = CW'(TAPS);
      end else begin
         taps_eff = CW'(tap_count_ff);
      end
   end

   // A word is taken only between outputs; the output register decouples the
   // response side, so a waiting result does not hold back the next word.
   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign accept_sample  = accept && (req_port.req_type == firfc_pkg::REQ_SAMPLE);

   // The sum at the end of the row is complete once the counter is done; it
   // is written out when the output register is free or being emptied.
   assign capture   = (state_ff == ST_CALC) && (cnt_ff == CNT_DONE) &&
                      (!rsp_valid_ff || rsp_port.ready);
   assign tail_left = (tail_ff != '0);

   always_comb begin
      ctrl.shift      = accept_sample || (capture && tail_left);
      ctrl.clear      = capture && !tail_left && last_ff;
      ctrl.coef_value = req_port.tap_value;
   end

   // A tail output shifts a zero sample in behind the last real one.
   assign sample_chain[0] = accept_sample ? req_port.sample_value : '0;
   assign sum_chain[0]    = '0;

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      logic coef_we;
      logic tap_enable;

      assign coef_we    = accept && (req_port.req_type == firfc_pkg::REQ_LOAD) &&
                          (32'(req_port.tap_index) == k);
      assign tap_enable = (k < 32'(taps_ff));

      firfc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .coef_we    (coef_we),
         .tap_enable (tap_enable),
         .sample_in  (sample_chain[k]),
         .sample_out (sample_chain[k+1]),
         .sum_in     (sum_chain[k]),
         .sum_out    (sum_chain[k+1])
      );
   end

   // Sequencer, configuration register and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tail_ff      <= '0;
         taps_ff      <= CW'(TAPS);
         last_ff      <= 1'b0;
         tap_count_ff <= firfc_pkg::COUNT_W'(16);
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            tap_count_ff <= csr_wdata;
         end

         // A new output word refills the register in the cycle that the old
         // one leaves, so the two cases never coincide with an empty slot.
         if (capture) begin
            rsp_valid_ff <= 1'b1;
            rsp_last_ff  <= last_ff && !tail_left;
         end else if (rsp_valid_ff && rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept_sample) begin
                  state_ff <= ST_CALC;
                  cnt_ff   <= '0;
                  taps_ff  <= taps_eff;
                  last_ff  <= req_port.last_sample;
                  tail_ff  <= req_port.last_sample ? taps_eff - CW'(1) : '0;
               end
            end
            ST_CALC: begin
               if (capture) begin
                  if (tail_left) begin
                     tail_ff <= tail_ff - CW'(1);
                     cnt_ff  <= '0;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else if (cnt_ff != CNT_DONE) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_value_ff <= sum_chain[TAPS];
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.filtered_value = rsp_value_ff;
   assign rsp_port.last_output    = rsp_last_ff;

   // A sample word always starts a convolution pass.
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      accept_sample |=> (state_ff == ST_CALC))
      else $error("sample word did not start a pass");

   // The tail never outnumbers the active taps.
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (tail_ff < taps_ff))
      else $error("tail count beyond active taps");

   // The settle counter stops at its done value.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_DONE)
      else $error("settle counter overran");

   // After the final word of a block the delay line starts from zero.
   a_block_clear: assert property (@(posedge clock) disable iff (reset)
      (capture && !tail_left && last_ff) |=> (sample_chain[1] == '0))
      else $error("delay line not cleared after block");

endmodule
